// ===== hdl/cbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfp_pkg: shared constants for the compass bearing core
// Fixed-point formats, circle constants and the CORDIC arc-tangent table.
// ----------------------------------------------------------------------------
package cbfp_pkg;

	// differences are scaled up by this many bits before the CORDIC
	localparam int GUARD_BITS   = 20;
	// number of entries in the arc-tangent table
	localparam int ATAN_ENTRIES = 24;
	// angle accumulator holds degrees times 2^DEG_SHIFT
	localparam int DEG_SHIFT    = 16;
	// output carries 7 fraction bits
	localparam int OUT_SHIFT    = DEG_SHIFT - 7;
	// signed width of the angle accumulator (covers about -100..280 degrees)
	localparam int ZW           = 27;
	// unsigned width of a folded angle in [0, 360) degrees
	localparam int FW           = 25;
	// output field width
	localparam int BW           = 16;

	localparam logic signed [ZW-1:0] HALF_CIRCLE = ZW'(180 << DEG_SHIFT);
	localparam logic signed [ZW-1:0] FULL_CIRCLE = ZW'(360 << DEG_SHIFT);
	localparam logic [FW:0]          OUT_ROUND   = (FW+1)'(1 << (OUT_SHIFT - 1));
	localparam logic [FW-OUT_SHIFT:0] OUT_CIRCLE = (FW-OUT_SHIFT+1)'(46080);

	// atan(2^-idx) in degrees times 2^16, rounded to nearest
	function automatic logic [ZW-1:0] atan_deg(input int unsigned idx);
		logic [ZW-1:0] a;
		case (idx)
			0:       a = ZW'(2949120);
			1:       a = ZW'(1740967);
			2:       a = ZW'(919879);
			3:       a = ZW'(466945);
			4:       a = ZW'(234379);
			5:       a = ZW'(117304);
			6:       a = ZW'(58666);
			7:       a = ZW'(29335);
			8:       a = ZW'(14668);
			9:       a = ZW'(7334);
			10:      a = ZW'(3667);
			11:      a = ZW'(1833);
			12:      a = ZW'(917);
			13:      a = ZW'(458);
			14:      a = ZW'(229);
			15:      a = ZW'(115);
			16:      a = ZW'(57);
			17:      a = ZW'(29);
			18:      a = ZW'(14);
			19:      a = ZW'(7);
			20:      a = ZW'(4);
			21:      a = ZW'(2);
			22:      a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/cbfp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// cbfp_cordic_stage: one CORDIC vectoring micro-rotation
// Rotates the vector toward the first axis by atan(2^-SHIFT) and updates the
// angle accumulator, behind a registered valid/ready stage.
// ----------------------------------------------------------------------------
module cbfp_cordic_stage #(
	parameter int W     = 39,
	parameter int SHIFT = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [W-1:0]            in_vx,
	input  logic signed [W-1:0]            in_vy,
	input  logic signed [cbfp_pkg::ZW-1:0] in_z,
	input  logic                           in_zero,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [W-1:0]            out_vx,
	output logic signed [W-1:0]            out_vy,
	output logic signed [cbfp_pkg::ZW-1:0] out_z,
	output logic                           out_zero
);

	localparam logic signed [cbfp_pkg::ZW-1:0] ATAN = cbfp_pkg::atan_deg(SHIFT);

	logic                           v_s1;
	logic signed [W-1:0]            vx_s1;
	logic signed [W-1:0]            vy_s1;
	logic signed [cbfp_pkg::ZW-1:0] z_s1;
	logic                           zero_s1;

	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic                pos;
	logic                take;

	// shifted terms, floor rounding
	assign xs  = in_vx >>> SHIFT;
	assign ys  = in_vy >>> SHIFT;
	assign pos = !in_vy[W-1] && (|in_vy);

	// take a word when this stage is empty or drains this cycle
	assign in_ready = !v_s1 || out_ready;
	assign take     = in_valid && in_ready;

	// hold the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// rotate toward the axis, steered by the sign of vy
	always_ff @(posedge clk) begin
		if (take) begin
			if (pos) begin
				vx_s1 <= in_vx + ys;
				vy_s1 <= in_vy - xs;
				z_s1  <= in_z + ATAN;
			end else begin
				vx_s1 <= in_vx - ys;
				vy_s1 <= in_vy + xs;
				z_s1  <= in_z - ATAN;
			end
			zero_s1 <= in_zero;
		end
	end

	assign out_valid = v_s1;
	assign out_vx    = vx_s1;
	assign out_vy    = vy_s1;
	assign out_z     = z_s1;
	assign out_zero  = zero_s1;

endmodule

// ===== hdl/compass_bearing_from_points_core.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_from_points_core: clockwise bearing between two points
// Throughput: one word per cycle; each stage (a CORDIC stage does one
// micro-rotation) holds its word only while the next one is full and stalled.
// Reset clears the valid bits only; the block keeps no other state.
// Bearing is degrees times 128 in [0, 46080), zero for equal points.
// ----------------------------------------------------------------------------
module compass_bearing_from_points_core #(
	parameter int COORD_BITS       = 16,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  dest_x,
	input  logic signed [COORD_BITS-1:0]  dest_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cbfp_pkg::BW-1:0]       bearing
);

	localparam int DW    = COORD_BITS + 1;
	localparam int W     = COORD_BITS + cbfp_pkg::GUARD_BITS + 3;
	localparam int ITERS = (ANGLE_ITERATIONS < cbfp_pkg::ATAN_ENTRIES) ?
		ANGLE_ITERATIONS : cbfp_pkg::ATAN_ENTRIES;
	localparam int ZW    = cbfp_pkg::ZW;
	localparam int FW    = cbfp_pkg::FW;
	localparam int RW    = FW - cbfp_pkg::OUT_SHIFT + 1;

	// stage 1: differences
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic                 rdy_s1;

	// stage 2: scaled, pre-rotated vector
	logic                 v_s2;
	logic signed [W-1:0]  vx_s2;
	logic signed [W-1:0]  vy_s2;
	logic signed [ZW-1:0] z_s2;
	logic                 zero_s2;
	logic                 rdy_s2;

	// CORDIC chain taps
	logic                 c_valid [ITERS+1];
	logic                 c_ready [ITERS+1];
	logic signed [W-1:0]  c_vx    [ITERS+1];
	logic signed [W-1:0]  c_vy    [ITERS+1];
	logic signed [ZW-1:0] c_z     [ITERS+1];
	logic                 c_zero  [ITERS+1];

	// post-CORDIC stage 3: angle folded into one turn
	logic                 v_s3;
	logic [FW-1:0]        zf_s3;
	logic                 zero_s3;
	logic                 rdy_s3;

	// post-CORDIC stage 4: rounded output register
	logic                 v_s4;
	logic [cbfp_pkg::BW-1:0] b_s4;
	logic                 rdy_s4;

	logic signed [W-1:0]  vx_pre;
	logic signed [W-1:0]  vy_pre;
	logic signed [ZW-1:0] z_fold;
	logic [FW:0]          z_rnd;
	logic [RW-1:0]        r_raw;
	logic [RW-1:0]        r_wrap;

	// ready chain: a stage moves when empty or when its successor moves
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || c_ready[0];
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: form the differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			dx_s1 <= DW'(dest_x) - DW'(start_x);
			dy_s1 <= DW'(dest_y) - DW'(start_y);
		end
	end

	// stage 2: swap axes, scale, and rotate by half a turn when dy is negative
	assign vx_pre = W'(dy_s1) <<< cbfp_pkg::GUARD_BITS;
	assign vy_pre = W'(dx_s1) <<< cbfp_pkg::GUARD_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			if (dy_s1[DW-1]) begin
				vx_s2 <= -vx_pre;
				vy_s2 <= -vy_pre;
				z_s2  <= cbfp_pkg::HALF_CIRCLE;
			end else begin
				vx_s2 <= vx_pre;
				vy_s2 <= vy_pre;
				z_s2  <= '0;
			end
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
		end
	end

	assign c_valid[0] = v_s2;
	assign c_vx[0]    = vx_s2;
	assign c_vy[0]    = vy_s2;
	assign c_z[0]     = z_s2;
	assign c_zero[0]  = zero_s2;

	// CORDIC micro-rotations, one per stage
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		cbfp_cordic_stage #(
			.W     (W),
			.SHIFT (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_vx     (c_vx[i]),
			.in_vy     (c_vy[i]),
			.in_z      (c_z[i]),
			.in_zero   (c_zero[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_vx    (c_vx[i+1]),
			.out_vy    (c_vy[i+1]),
			.out_z     (c_z[i+1]),
			.out_zero  (c_zero[i+1])
		);
	end

	assign c_ready[ITERS] = rdy_s3;

	// stage 3: fold the angle into one turn; it never reaches a full turn
	assign z_fold = c_z[ITERS][ZW-1] ? (c_z[ITERS] + cbfp_pkg::FULL_CIRCLE) : c_z[ITERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= c_valid[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (c_valid[ITERS] && rdy_s3) begin
			zf_s3   <= z_fold[FW-1:0];
			zero_s3 <= c_zero[ITERS];
		end
	end

	// stage 4: round to 7 fraction bits, wrap a full turn to zero
	assign z_rnd  = {1'b0, zf_s3} + cbfp_pkg::OUT_ROUND;
	assign r_raw  = z_rnd[FW:cbfp_pkg::OUT_SHIFT];
	assign r_wrap = (r_raw >= cbfp_pkg::OUT_CIRCLE) ? (r_raw - cbfp_pkg::OUT_CIRCLE) : r_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			b_s4 <= zero_s3 ? '0 : r_wrap[cbfp_pkg::BW-1:0];
		end
	end

	assign out_valid = v_s4;
	assign bearing   = b_s4;

`ifndef SYNTHESIS
	// pre-rotation leaves the vector in the right half plane
	a_prerot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !vx_s2[W-1])
		else $error("pre-rotated vx is negative");

	// starting angle is zero or half a turn
	a_prerot_angle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (z_s2 == '0 || z_s2 == cbfp_pkg::HALF_CIRCLE))
		else $error("bad starting angle");

	// folded angle stays below a full turn
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ({2'b00, zf_s3} < cbfp_pkg::FULL_CIRCLE))
		else $error("folded angle out of range");

	// a word moved out of stage 3 lands in the output register
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_s4) |=> v_s4)
		else $error("word lost between stage 3 and output");

	// bearing below a full turn
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bearing < 16'd46080))
		else $error("bearing out of range");
`endif

endmodule

// ===== tb/sv/compass_bearing_checker.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_checker: scoreboard for the compass bearing core
// Watches both channels of the core. Each accepted coordinate word is turned
// into an expected bearing by a CORDIC vectoring model kept here, in plain
// integer arithmetic. Each accepted result is compared with the oldest
// expected bearing. Mismatches and results that nobody asked for are counted.
// ----------------------------------------------------------------------------
module compass_bearing_checker #(
	parameter int COORD_BITS       = 16,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  dest_x,
	input  logic signed [COORD_BITS-1:0]  dest_y,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [cbfp_pkg::BW-1:0]       bearing,
	output int                            mismatches,
	output int                            words_in_flight
);

	localparam longint TURN_UNITS    = longint'(360) << cbfp_pkg::DEG_SHIFT;
	localparam longint HALF_UNITS    = longint'(180) << cbfp_pkg::DEG_SHIFT;
	localparam longint OUT_TURN      = 46080;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
		logic [cbfp_pkg::BW-1:0]      bearing;
	} bearing_word_t;

	bearing_word_t pending_bearings[$];
	// arc-tangent steps, degrees times 2^16
	longint atan_step [24];

	initial begin
		atan_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115,
			57, 29, 14, 7, 4, 2, 1, 0};
		mismatches = 0;
		words_in_flight = 0;
	end

	// Bearing clockwise from +y: rotate (dy, dx) onto its first axis and
	// accumulate the angle, then fold into one turn and round to 1/128 degree.
	function automatic logic [cbfp_pkg::BW-1:0] compass_bearing(
		input logic signed [COORD_BITS-1:0] sx,
		input logic signed [COORD_BITS-1:0] sy,
		input logic signed [COORD_BITS-1:0] ex,
		input logic signed [COORD_BITS-1:0] ey
	);
		longint dx, dy, vx, vy, z, t, xs, ys, r;
		dx = longint'(ex) - longint'(sx);
		dy = longint'(ey) - longint'(sy);
		if (dx == 0 && dy == 0)
			return '0;
		vx = dy <<< cbfp_pkg::GUARD_BITS;
		vy = dx <<< cbfp_pkg::GUARD_BITS;
		z = 0;
		// pre-rotate by half a turn into the right half plane
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			z = HALF_UNITS;
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < cbfp_pkg::ATAN_ENTRIES; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy > 0) begin
				t = vx + ys;
				vy = vy - xs;
				z = z + atan_step[i];
			end else begin
				t = vx - ys;
				vy = vy + xs;
				z = z - atan_step[i];
			end
			vx = t;
		end
		if (z < 0)
			z = z + TURN_UNITS;
		if (z >= TURN_UNITS)
			z = z - TURN_UNITS;
		r = (z + (longint'(1) << (cbfp_pkg::OUT_SHIFT - 1))) >>> cbfp_pkg::OUT_SHIFT;
		// a bearing that rounds up to the full turn wraps to north
		if (r >= OUT_TURN)
			r = r - OUT_TURN;
		return cbfp_pkg::BW'(r);
	endfunction

	// Compare results first, then queue the new expectation
	always @(posedge clk) begin : watch
		bearing_word_t want;
		bearing_word_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_bearings.size() == 0) begin
					$display("%0t unexpected bearing word %0d", $time, bearing);
					mismatches++;
				end else begin
					want = pending_bearings.pop_front();
					if (bearing !== want.bearing) begin
						$display("%0t bearing mismatch (%0d,%0d)->(%0d,%0d): expected %0d, actual %0d",
							$time, want.sx, want.sy, want.ex, want.ey, want.bearing, bearing);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				got.sx = start_x;
				got.sy = start_y;
				got.ex = dest_x;
				got.ey = dest_y;
				got.bearing = compass_bearing(start_x, start_y, dest_x, dest_y);
				pending_bearings.insert(pending_bearings.size(), got);
			end
			words_in_flight = pending_bearings.size();
		end
	end

endmodule

// ===== tb/sv/compass_bearing_from_points_core_test.sv =====
// ----------------------------------------------------------------------------
// compass_bearing_from_points_core_test: testbench top for the bearing core
// Drives coordinate words into the core: a directed set of compass points,
// equal points and extreme differences, then random words of several shapes
// under changing sender and receiver idle rates, one long receiver hold-off
// and full drains. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module compass_bearing_from_points_core_test;

	localparam int COORD_BITS   = 16;
	localparam int HOLD_CYCLES  = 160;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_WORDS  = 630;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [COORD_BITS-1:0]  start_x;
	logic signed [COORD_BITS-1:0]  start_y;
	logic signed [COORD_BITS-1:0]  dest_x;
	logic signed [COORD_BITS-1:0]  dest_y;
	logic                          out_valid;
	logic                          out_ready;
	logic [cbfp_pkg::BW-1:0]       bearing;
	int                            mismatches;
	int                            words_in_flight;
	int                            idle_in = 28;
	int                            idle_out = 52;
	int                            holds_asked = 0;
	int                            holds_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	compass_bearing_from_points_core #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_ITERATIONS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bearing(bearing)
	);

	compass_bearing_checker #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_ITERATIONS(16)
	) bearing_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bearing(bearing),
		.mismatches(mismatches),
		.words_in_flight(words_in_flight)
	);

	// Abort a hung run
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random back-pressure, plus a long hold-off when asked
	initial begin : receiver
		out_ready = 1'b0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else
				out_ready <= ($urandom_range(99) >= idle_out);
		end
	end

	function automatic logic signed [COORD_BITS-1:0] clip_coord(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] edge_coord();
		case ($urandom_range(6))
			0:       return -16'sd32768;
			1:       return -16'sd32767;
			2:       return -16'sd1;
			3:       return 16'sd0;
			4:       return 16'sd1;
			5:       return 16'sd32766;
			default: return 16'sd32767;
		endcase
	endfunction

	// Offer one word, with a random gap first; return at its accept edge
	task automatic send_word(
		input logic signed [COORD_BITS-1:0] sx,
		input logic signed [COORD_BITS-1:0] sy,
		input logic signed [COORD_BITS-1:0] ex,
		input logic signed [COORD_BITS-1:0] ey
	);
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_in);
		end
		in_valid <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		dest_x <= ex;
		dest_y <= ey;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold until every expected bearing has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_in_flight != 0);
		@(posedge clk);
	endtask

	// Random word: full range, short hops, near-axis, equal points, edges
	task automatic random_word();
		logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
		int pick, span, ox, oy;
		pick = $urandom_range(99);
		sx = COORD_BITS'($urandom);
		sy = COORD_BITS'($urandom);
		ex = COORD_BITS'($urandom);
		ey = COORD_BITS'($urandom);
		if (pick >= 40 && pick < 70) begin
			span = 1 << $urandom_range(12);
			ox = int'($urandom_range(2 * span)) - span;
			oy = int'($urandom_range(2 * span)) - span;
			ex = clip_coord(int'(sx) + ox);
			ey = clip_coord(int'(sy) + oy);
		end else if (pick >= 70 && pick < 85) begin
			ox = int'($urandom_range(6)) - 3;
			oy = int'($urandom_range(131070)) - 65535;
			if ($urandom_range(1)) begin
				ex = clip_coord(int'(sx) + ox);
				ey = clip_coord(int'(sy) + oy);
			end else begin
				ex = clip_coord(int'(sx) + oy);
				ey = clip_coord(int'(sy) + ox);
			end
		end else if (pick >= 85 && pick < 95) begin
			ex = sx;
			ey = sy;
		end else if (pick >= 95) begin
			sx = edge_coord();
			sy = edge_coord();
			ex = edge_coord();
			ey = edge_coord();
		end
		send_word(sx, sy, ex, ey);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_x = '0;
		start_y = '0;
		dest_x = '0;
		dest_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal points, including at the corners of the plane
		send_word(0, 0, 0, 0);
		send_word(32767, 32767, 32767, 32767);
		send_word(-32768, -32768, -32768, -32768);
		// compass points
		send_word(0, 0, 0, 100);
		send_word(0, 0, 100, 0);
		send_word(0, 0, 0, -100);
		send_word(0, 0, -100, 0);
		send_word(0, 0, 1, 1);
		send_word(0, 0, -1, -1);
		send_word(0, 0, 1, -1);
		send_word(0, 0, -1, 1);
		// largest differences along all four diagonals and two axes
		send_word(-32768, -32768, 32767, 32767);
		send_word(32767, 32767, -32768, -32768);
		send_word(-32768, 32767, 32767, -32768);
		send_word(32767, -32768, -32768, 32767);
		send_word(-32768, 0, 32767, 0);
		send_word(0, 32767, 0, -32768);
		// just west and east of north: the west ones round up to the full turn and wrap
		send_word(0, -32768, -1, 32767);
		send_word(0, -32768, -2, 32767);
		send_word(0, -32768, 1, 32767);
		// just east and west of south
		send_word(0, 32767, 1, -32768);
		send_word(0, 32767, -1, -32768);
		// unit steps off the axes
		send_word(5, 5, 6, 5);
		send_word(5, 5, 5, 4);
		drain();

		// sender idles less than receiver; one long receiver hold-off
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (n == 200)
				holds_asked++;
			random_word();
		end
		drain();

		// receiver idles less than sender; one mid-phase pause
		idle_in = 52;
		idle_out = 28;
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (n == 300)
				drain();
			random_word();
		end
		drain();

		// back to back, no idling on either side
		idle_in = 0;
		idle_out = 0;
		for (int n = 0; n < PHASE_WORDS + 10; n++)
			random_word();
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_in_flight == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
